FILE: rtl/sndx_pkg.sv
// Shared types, constants and character helpers for the soundex encoder.
`timescale 1ns / 1ps
`default_nettype none

package sndx_pkg;

  localparam int CODE_LEN = 4;
  localparam int CNT_W    = $clog2(CODE_LEN + 1);
  localparam int IDX_W    = $clog2(CODE_LEN);
  localparam int OUT_SYMS = (CODE_LEN < 4) ? CODE_LEN : 4;

  localparam logic [7:0] PAD_SYMBOL = 8'h30;
  localparam logic [7:0] CHAR_A_UP  = 8'h41;
  localparam logic [7:0] CHAR_Z_UP  = 8'h5A;
  localparam logic [7:0] CHAR_A_LO  = 8'h61;
  localparam logic [7:0] CHAR_Z_LO  = 8'h7A;
  localparam logic [7:0] CASE_DIFF  = 8'h20;

  // previous code: digit 0..6, or the no-code marker
  localparam logic [3:0] NO_CODE = 4'hF;

  typedef struct packed {
    logic [7:0] char_byte;
    logic       end_of_string;
  } in_req_t;

  typedef struct packed {
    logic [31:0] code_word;
    logic        status;
  } out_req_t;

  function automatic logic is_letter(input logic [7:0] c);
    return ((c >= CHAR_A_UP) && (c <= CHAR_Z_UP)) || ((c >= CHAR_A_LO) && (c <= CHAR_Z_LO));
  endfunction

  function automatic logic [7:0] to_upper(input logic [7:0] c);
    return ((c >= CHAR_A_LO) && (c <= CHAR_Z_LO)) ? c - CASE_DIFF : c;
  endfunction

  // digit of letter index 0 (A) .. 25 (Z): "01230120022455012623010202"
  function automatic logic [2:0] letter_digit(input logic [4:0] idx);
    logic [2:0] d;
    unique case (idx)
      5'd1, 5'd5, 5'd15, 5'd21:                          d = 3'd1;
      5'd2, 5'd6, 5'd9, 5'd10, 5'd16, 5'd18, 5'd23, 5'd25: d = 3'd2;
      5'd3, 5'd19:                                       d = 3'd3;
      5'd11:                                             d = 3'd4;
      5'd12, 5'd13:                                      d = 3'd5;
      5'd17:                                             d = 3'd6;
      default:                                           d = 3'd0;
    endcase
    return d;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/sndx_in_stage.sv
// Input register holding one character request ahead of the encoder.
`timescale 1ns / 1ps
`default_nettype none

module sndx_in_stage
  import sndx_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    in_valid,
  output logic         in_stall,
  input  wire in_req_t in_req,
  input  wire logic    advance,
  output logic         item_valid,
  output in_req_t      item
);

  logic    valid_r;
  in_req_t item_r;

  assign in_stall   = valid_r && !advance;
  assign item_valid = valid_r;
  assign item       = item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_valid && !in_stall) begin
      valid_r <= 1'b1;
    end else if (advance) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      item_r <= in_req;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/sndx_core.sv
// Per-string encoder state and the single-pass symbol update and code packing.
`timescale 1ns / 1ps
`default_nettype none

module sndx_core
  import sndx_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    fire,
  input  wire in_req_t item,
  input  wire logic    fold_case,
  output logic         res_valid,
  output out_req_t     res
);

  logic [7:0]       store_r [CODE_LEN];
  logic [7:0]       store_nxt [CODE_LEN];
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [3:0]       prev_r, prev_nxt;
  logic             seen_r, seen_nxt;

  logic       letter;
  logic [7:0] upper;
  logic [4:0] idx;
  logic [2:0] dig;

  assign letter = is_letter(item.char_byte);
  assign upper  = to_upper(item.char_byte);
  assign idx    = 5'(upper - CHAR_A_UP);
  assign dig    = letter_digit(idx);

  always_comb begin
    store_nxt = store_r;
    count_nxt = count_r;
    prev_nxt  = prev_r;
    seen_nxt  = seen_r;
    if (!seen_r) begin
      if (letter) begin
        store_nxt[0] = fold_case ? upper : item.char_byte;
        count_nxt    = CNT_W'(1);
        prev_nxt     = NO_CODE;
        seen_nxt     = 1'b1;
      end
    end else if (count_r < CNT_W'(CODE_LEN)) begin
      if (letter) begin
        if ((dig != 3'd0) && ({1'b0, dig} != prev_r)) begin
          store_nxt[count_r[IDX_W-1:0]] = PAD_SYMBOL + {5'd0, dig};
          count_nxt = count_r + CNT_W'(1);
        end
        prev_nxt = {1'b0, dig};
      end else begin
        prev_nxt = NO_CODE;
      end
    end
  end

  always_comb begin
    res.code_word = '0;
    res.status    = !seen_nxt;
    if (seen_nxt) begin
      for (int i = 0; i < OUT_SYMS; i++) begin
        res.code_word[31 - 8 * i -: 8] =
          (CNT_W'(i) < count_nxt) ? store_nxt[i] : PAD_SYMBOL;
      end
    end
  end

  assign res_valid = fire && item.end_of_string;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      prev_r  <= NO_CODE;
      seen_r  <= 1'b0;
    end else if (fire) begin
      if (item.end_of_string) begin
        count_r <= '0;
        prev_r  <= NO_CODE;
        seen_r  <= 1'b0;
      end else begin
        count_r <= count_nxt;
        prev_r  <= prev_nxt;
        seen_r  <= seen_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      store_r <= store_nxt;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(CODE_LEN))
    else $error("symbol count beyond code length");

  a_seen_count: assert property (@(posedge clk) disable iff (!rst_n)
    seen_r == (count_r != '0))
    else $error("letter flag and symbol count disagree");

  a_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
    fire && item.end_of_string |=> !seen_r && (count_r == '0) && (prev_r == NO_CODE))
    else $error("string state not cleared after end of string");

  a_first_no_code: assert property (@(posedge clk) disable iff (!rst_n)
    fire && !seen_r && letter && !item.end_of_string |=> prev_r == NO_CODE)
    else $error("first letter left a previous code");

endmodule

`default_nettype wire

FILE: rtl/sndx_out_reg.sv
// Result register driving the output channel.
`timescale 1ns / 1ps
`default_nettype none

module sndx_out_reg
  import sndx_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     load,
  input  wire out_req_t res,
  output logic          can_load,
  output logic          out_valid,
  input  wire logic     out_stall,
  output out_req_t      out_res
);

  logic     valid_r;
  out_req_t res_r;

  assign can_load  = !valid_r || !out_stall;
  assign out_valid = valid_r;
  assign out_res   = res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (load && can_load) begin
      valid_r <= 1'b1;
    end else if (!out_stall) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load && can_load) begin
      res_r <= res;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/soundex_encoder_unit.sv
// Top level of the soundex encoder: input stage, encoder core, result register.
//
//   channel  direction  handshake          payload
//   in       input      in_valid/in_stall  in_req  (char_byte, end_of_string)
//   out      output     out_valid/out_stall out_res (code_word, status)
//   cfg      input      cfg_wr_en          cfg_wr_data (fold_case)
//
// One character per cycle unless in_stall; out_valid is set as the result register loads.
// The encoder core updates the per-string state once per character.
// Reset (synchronous, rst_n low) clears the string state and fold_case.
// Only end-of-string requests wait on a stalled result register; other
// characters keep flowing through the core while a result is held.
`timescale 1ns / 1ps
`default_nettype none

module soundex_encoder_unit
  import sndx_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_stall,
  input  wire in_req_t  in_req,
  output logic          out_valid,
  input  wire logic     out_stall,
  output out_req_t      out_res,
  input  wire logic     cfg_wr_en,
  input  wire logic     cfg_wr_data
);

  logic     fold_case_r;
  logic     item_valid;
  in_req_t  item;
  logic     can_load;
  logic     advance;
  logic     res_valid;
  out_req_t res;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fold_case_r <= 1'b0;
    end else if (cfg_wr_en) begin
      fold_case_r <= cfg_wr_data;
    end
  end

  assign advance = item_valid && (!item.end_of_string || can_load);

  sndx_in_stage u_in_stage (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_req     (in_req),
    .advance    (advance),
    .item_valid (item_valid),
    .item       (item)
  );

  sndx_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .fire      (advance),
    .item      (item),
    .fold_case (fold_case_r),
    .res_valid (res_valid),
    .res       (res)
  );

  sndx_out_reg u_out_reg (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (res_valid),
    .res       (res),
    .can_load  (can_load),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_res   (out_res)
  );

endmodule

`default_nettype wire
